// ===== hdl/fde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_pkg: shared definitions of the form field extract and decode unit
// Character codes, state encodings, the command passed from the front end
// to the back end, and small helper functions.
// ----------------------------------------------------------------------------
package fde_pkg;

  localparam int MAX_KEY_CHARS = 8;
  localparam int KEY_BITS      = 8 * MAX_KEY_CHARS;
  localparam int KIDX_W        = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam int KPOS_W        = 4;

  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam int REG_SEL = 3;

  typedef enum logic {
    REG_KEY_CHARS  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } reg_idx_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_SKIP,
    PH_EMIT,
    PH_STOP,
    PH_DRAIN
  } phase_t;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_FIRST,
    ESC_SECOND,
    ESC_DROP
  } esc_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_GT,
    CMD_LT,
    CMD_BR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       has_done;
    logic       found;
  } cmd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    logic       v;
    d = 8'h00;
    v = 1'b0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      v = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      v = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      v = 1'b1;
    end
    return {v, d[3:0]};
  endfunction

  function automatic logic key_match(input logic [KPOS_W-1:0] kpos, input logic ksm,
                                     input logic [KPOS_W-1:0] klen);
    return ksm && (klen != '0) && (klen <= KPOS_W'(MAX_KEY_CHARS)) && (kpos == klen);
  endfunction

  function automatic logic [2:0] body_count(input cmd_kind_t kind);
    logic [2:0] n;
    case (kind)
      CMD_CHAR:                n = 3'd1;
      CMD_GT, CMD_LT, CMD_BR:  n = 3'd4;
      default:                 n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] entity_byte(input cmd_kind_t kind, input logic [1:0] idx);
    logic [7:0] b;
    b = CH_NUL;
    case (kind)
      CMD_GT: begin
        case (idx)
          2'd0:    b = CH_AMP;
          2'd1:    b = CH_G;
          2'd2:    b = CH_T;
          default: b = CH_SEMI;
        endcase
      end
      CMD_LT: begin
        case (idx)
          2'd0:    b = CH_AMP;
          2'd1:    b = CH_L;
          2'd2:    b = CH_T;
          default: b = CH_SEMI;
        endcase
      end
      CMD_BR: begin
        case (idx)
          2'd0:    b = CH_LT;
          2'd1:    b = CH_B;
          2'd2:    b = CH_R;
          default: b = CH_GT;
        endcase
      end
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/fde_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_front: field parser and decoder
// Tracks the key match and escape state one raw byte per cycle while accept
// is high and turns each byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module fde_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [7:0]                    in_byte,
  input  logic                          in_is_final,
  input  logic [fde_pkg::KEY_BITS-1:0]  key_chars,
  input  logic [fde_pkg::KPOS_W-1:0]    key_length,
  output fde_pkg::cmd_t                 cmd,
  output logic                          cmd_push
);

  fde_pkg::phase_t              phase_r, phase_nxt, phase_mid;
  logic [fde_pkg::KPOS_W-1:0]   kpos_r, kpos_nxt, kpos_mid;
  logic                         ksm_r, ksm_nxt, ksm_mid;
  fde_pkg::esc_t                esc_r, esc_nxt, esc_mid;
  logic [7:0]                   hex_r, hex_nxt, hex_mid;

  logic                         done_sent;
  logic                         put_en;
  logic [7:0]                   put_byte;
  logic                         start;
  logic [4:0]                   hex_d;
  logic [7:0]                   want;
  logic                         km_cur;
  logic                         fin_done;
  logic                         fin_found;

  assign hex_d  = fde_pkg::hex_digit(in_byte);
  assign want   = key_chars[8*kpos_r[fde_pkg::KIDX_W-1:0] +: 8];
  assign km_cur = fde_pkg::key_match(kpos_r, ksm_r, key_length);

  // Effect of the byte before the end-of-form handling.
  always_comb begin
    phase_mid = phase_r;
    kpos_mid  = kpos_r;
    ksm_mid   = ksm_r;
    esc_mid   = esc_r;
    hex_mid   = hex_r;
    done_sent = 1'b0;
    put_en    = 1'b0;
    put_byte  = in_byte;
    start     = 1'b0;
    case (phase_r)
      fde_pkg::PH_KEY: begin
        if (in_byte == fde_pkg::CH_AMP) begin
          if (kpos_r != '0 && km_cur) begin
            done_sent = 1'b1;
            phase_mid = fde_pkg::PH_DRAIN;
          end else begin
            start = 1'b1;
          end
        end else if (in_byte == fde_pkg::CH_EQ) begin
          // Leading '=' of a key are skipped.
          if (kpos_r != '0) begin
            phase_mid = km_cur ? fde_pkg::PH_EMIT : fde_pkg::PH_SKIP;
            esc_mid   = fde_pkg::ESC_IDLE;
            hex_mid   = 8'h00;
          end
        end else begin
          if (kpos_r < key_length && kpos_r < fde_pkg::KPOS_W'(fde_pkg::MAX_KEY_CHARS)) begin
            if (fde_pkg::to_lower(want) != fde_pkg::to_lower(in_byte)) begin
              ksm_mid = 1'b0;
            end
          end else begin
            ksm_mid = 1'b0;
          end
          if (kpos_r <= fde_pkg::KPOS_W'(fde_pkg::MAX_KEY_CHARS)) begin
            kpos_mid = kpos_r + 1'b1;
          end
        end
      end
      fde_pkg::PH_SKIP: begin
        if (in_byte == fde_pkg::CH_AMP) begin
          start = 1'b1;
        end
      end
      fde_pkg::PH_EMIT, fde_pkg::PH_STOP: begin
        if (in_byte == fde_pkg::CH_AMP) begin
          done_sent = 1'b1;
          phase_mid = fde_pkg::PH_DRAIN;
        end else if (phase_r == fde_pkg::PH_EMIT) begin
          case (esc_r)
            fde_pkg::ESC_FIRST: begin
              if (hex_d[4]) begin
                hex_mid = {4'h0, hex_d[3:0]};
                esc_mid = fde_pkg::ESC_SECOND;
              end else begin
                esc_mid = fde_pkg::ESC_DROP;
              end
            end
            fde_pkg::ESC_SECOND: begin
              // A bad second digit leaves the first digit as the value.
              esc_mid  = fde_pkg::ESC_IDLE;
              put_en   = 1'b1;
              put_byte = hex_d[4] ? {hex_r[3:0], hex_d[3:0]} : hex_r;
              hex_mid  = put_byte;
            end
            fde_pkg::ESC_DROP: begin
              esc_mid = fde_pkg::ESC_IDLE;
            end
            default: begin
              if (in_byte == fde_pkg::CH_PCT) begin
                esc_mid = fde_pkg::ESC_FIRST;
                hex_mid = 8'h00;
              end else if (in_byte == fde_pkg::CH_PLUS) begin
                put_en   = 1'b1;
                put_byte = fde_pkg::CH_SPACE;
              end else begin
                put_en = 1'b1;
              end
            end
          endcase
          if (put_en && put_byte == fde_pkg::CH_NUL) begin
            phase_mid = fde_pkg::PH_STOP;
          end
        end
      end
      default: begin
      end
    endcase
    if (start) begin
      phase_mid = fde_pkg::PH_KEY;
      kpos_mid  = '0;
      ksm_mid   = 1'b1;
      esc_mid   = fde_pkg::ESC_IDLE;
      hex_mid   = 8'h00;
    end
  end

  // Next state: a final byte always starts a new form.
  always_comb begin
    if (in_is_final) begin
      phase_nxt = fde_pkg::PH_KEY;
      kpos_nxt  = '0;
      ksm_nxt   = 1'b1;
      esc_nxt   = fde_pkg::ESC_IDLE;
      hex_nxt   = 8'h00;
    end else begin
      phase_nxt = phase_mid;
      kpos_nxt  = kpos_mid;
      ksm_nxt   = ksm_mid;
      esc_nxt   = esc_mid;
      hex_nxt   = hex_mid;
    end
  end

  // Command for the back end.
  always_comb begin
    fin_done  = in_is_final && !done_sent && phase_mid != fde_pkg::PH_DRAIN;
    fin_found = phase_mid == fde_pkg::PH_EMIT || phase_mid == fde_pkg::PH_STOP ||
                (phase_mid == fde_pkg::PH_KEY && kpos_mid != '0 &&
                 fde_pkg::key_match(kpos_mid, ksm_mid, key_length));
    cmd.data = put_byte;
    cmd.kind = fde_pkg::CMD_NONE;
    if (put_en) begin
      case (put_byte)
        fde_pkg::CH_NUL: cmd.kind = fde_pkg::CMD_NONE;
        fde_pkg::CH_GT:  cmd.kind = fde_pkg::CMD_GT;
        fde_pkg::CH_LT:  cmd.kind = fde_pkg::CMD_LT;
        fde_pkg::CH_NL:  cmd.kind = fde_pkg::CMD_BR;
        default:         cmd.kind = fde_pkg::CMD_CHAR;
      endcase
    end
    cmd.has_done = done_sent || fin_done;
    cmd.found    = done_sent ? 1'b1 : fin_found;
    cmd_push     = accept && (cmd.kind != fde_pkg::CMD_NONE || cmd.has_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fde_pkg::PH_KEY;
      kpos_r  <= '0;
      ksm_r   <= 1'b1;
      esc_r   <= fde_pkg::ESC_IDLE;
      hex_r   <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kpos_r  <= kpos_nxt;
      ksm_r   <= ksm_nxt;
      esc_r   <= esc_nxt;
      hex_r   <= hex_nxt;
    end
  end

  a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_is_final |=> phase_r == fde_pkg::PH_KEY && kpos_r == '0 && ksm_r)
    else $error("final byte did not restart the parser");

endmodule

// ===== hdl/fde_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_cmd_fifo: command queue between front end and back end
// A small first-in first-out store that lets either side stall alone.
// ----------------------------------------------------------------------------
module fde_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  fde_pkg::cmd_t  wr_data,
  input  logic           rd_en,
  output fde_pkg::cmd_t  rd_data,
  output logic           full,
  output logic           empty
);

  fde_pkg::cmd_t                  slot_r [fde_pkg::CMD_FIFO_DEPTH];
  logic [fde_pkg::CMD_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fde_pkg::CMD_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fde_pkg::CMD_CNT_W-1:0]  count_r, count_nxt;
  logic                           do_wr;
  logic                           do_rd;

  assign full    = count_r == fde_pkg::CMD_CNT_W'(fde_pkg::CMD_FIFO_DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == fde_pkg::CMD_PTR_W'(fde_pkg::CMD_FIFO_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == fde_pkg::CMD_PTR_W'(fde_pkg::CMD_FIFO_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("command written into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fde_pkg::CMD_CNT_W'(fde_pkg::CMD_FIFO_DEPTH))
    else $error("command queue count out of range");

endmodule

// ===== hdl/fde_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fde_back: result emitter
// Expands each queued command into its result beats into an output register
// that the consumer pops, one beat per cycle while no waiting beat is held.
// ----------------------------------------------------------------------------
module fde_back (
  input  logic           clk,
  input  logic           rst_n,
  input  fde_pkg::cmd_t  head,
  input  logic           head_empty,
  output logic           head_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_is_done,
  output logic           out_found,
  output logic           out_run_last
);

  logic [2:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        done_r, done_nxt;
  logic        found_r, found_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  n_body;
  logic [2:0]  total;
  logic        load;
  logic        item_last;

  assign n_body    = fde_pkg::body_count(head.kind);
  assign total     = n_body + {2'b00, head.has_done};
  assign load      = !head_empty && (!valid_r || pop);
  assign item_last = idx_r == (total - 3'd1);
  assign head_pop  = load && item_last;

  always_comb begin
    if (idx_r < n_body) begin
      byte_nxt  = (head.kind == fde_pkg::CMD_CHAR) ? head.data :
                  fde_pkg::entity_byte(head.kind, idx_r[1:0]);
      done_nxt  = 1'b0;
      found_nxt = 1'b0;
    end else begin
      byte_nxt  = fde_pkg::CH_NUL;
      done_nxt  = 1'b1;
      found_nxt = head.found;
    end
    last_nxt = item_last;
    if (load) begin
      idx_nxt = item_last ? 3'd0 : idx_r + 3'd1;
    end else begin
      idx_nxt = idx_r;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= byte_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
      last_r  <= last_nxt;
    end
  end

  assign empty        = !valid_r;
  assign out_byte     = byte_r;
  assign out_is_done  = done_r;
  assign out_found    = found_r;
  assign out_run_last = last_r;

  // The done marker is always the closing beat of its byte and carries zero.
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && done_r |-> last_r && byte_r == fde_pkg::CH_NUL)
    else $error("done marker is not the last beat or carries data");

  a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |=> valid_r && $stable(byte_r) && $stable(last_r))
    else $error("waiting result beat changed before it was taken");

endmodule

// ===== hdl/form_field_extract_decode_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_field_extract_decode_unit: form field extractor and percent decoder
// Finds the configured field in URL-encoded form data and emits its decoded
// value, HTML-escaped, followed by a done marker.
// ----------------------------------------------------------------------------
// One raw byte is accepted per cycle while full is low; the parser state is
// updated at the accepting edge and the byte becomes at most one command in a
// four-entry queue. The emitter drains the queue at one result beat per cycle
// while its output register is free or popped, so the first beat of a byte
// passes through the queue and then the output register before it shows on
// the result ports. A plain value byte gives one beat, while '<', '>' and a
// newline give four beats (five with a done marker), and the queue fills and
// raises full when such expansions arrive faster than the consumer pops. Bytes
// that give no result never wait on the emitter beyond queue space. Key name
// and length are written through the APB port; the low address bits below
// bit 3 are ignored. There is no clearing pass after reset.
module form_field_extract_decode_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte,
  input  logic                          in_is_final,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          out_is_done,
  output logic                          out_found,
  output logic                          out_run_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fde_pkg::PADDR_W-1:0]   paddr,
  input  logic [fde_pkg::PDATA_W-1:0]   pwdata,
  output logic [fde_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [fde_pkg::KEY_BITS-1:0]  key_chars_r;
  logic [fde_pkg::KPOS_W-1:0]    key_length_r;
  logic                          cfg_wr;
  fde_pkg::reg_idx_t             cfg_sel;
  logic                          accept;
  fde_pkg::cmd_t                 front_cmd;
  logic                          front_push;
  fde_pkg::cmd_t                 head_cmd;
  logic                          head_empty;
  logic                          head_pop;
  logic                          fifo_full;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = fde_pkg::reg_idx_t'(paddr[fde_pkg::REG_SEL]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r  <= '0;
      key_length_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        fde_pkg::REG_KEY_CHARS:  key_chars_r  <= pwdata[fde_pkg::KEY_BITS-1:0];
        fde_pkg::REG_KEY_LENGTH: key_length_r <= pwdata[fde_pkg::KPOS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      fde_pkg::REG_KEY_CHARS:  prdata = fde_pkg::PDATA_W'(key_chars_r);
      fde_pkg::REG_KEY_LENGTH: prdata = fde_pkg::PDATA_W'(key_length_r);
      default:                 prdata = '0;
    endcase
  end

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  fde_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_is_final (in_is_final),
    .key_chars   (key_chars_r),
    .key_length  (key_length_r),
    .cmd         (front_cmd),
    .cmd_push    (front_push)
  );

  fde_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_push),
    .wr_data (front_cmd),
    .rd_en   (head_pop),
    .rd_data (head_cmd),
    .full    (fifo_full),
    .empty   (head_empty)
  );

  fde_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head_cmd),
    .head_empty   (head_empty),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_is_done  (out_is_done),
    .out_found    (out_found),
    .out_run_last (out_run_last)
  );

endmodule

// ===== bench/form_field_extract_decode_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_field_extract_decode_unit_tb: self-checking bench for the form decoder
// Streams URL-encoded form bytes into the unit and checks every result beat
// against a cycle-free model of the field extractor. The field name is set
// through the APB port between phases. Both handshakes see random stalls.
// ----------------------------------------------------------------------------
module form_field_extract_decode_unit_tb;

  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 8;
  localparam int NUM_PHASES   = 7;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       found;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [7:0]                    in_byte = '0;
  logic                          in_is_final = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [7:0]                    out_byte;
  logic                          out_is_done;
  logic                          out_found;
  logic                          out_run_last;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [fde_pkg::PADDR_W-1:0]   paddr = '0;
  logic [fde_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [fde_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  // Model copy of the configuration and of the parser state.
  logic [63:0]      name_chars = '0;
  logic [3:0]       name_len = '0;
  fde_pkg::phase_t  parse_phase = fde_pkg::PH_KEY;
  logic [3:0]       key_pos = '0;
  logic             key_ok = 1'b1;
  fde_pkg::esc_t    esc = fde_pkg::ESC_IDLE;
  logic [7:0]       hex_acc = '0;

  beat_t       step_beats[$];
  beat_t       expected_beats[$];
  raw_t        form_stream[$];
  logic [7:0]  form_bytes[$];
  int          queued_bytes = 0;
  int          mismatches = 0;
  int          cycles = 0;
  logic        steady = 1'b0;

  form_field_extract_decode_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .in_is_final  (in_is_final),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_is_done  (out_is_done),
    .out_found    (out_found),
    .out_run_last (out_run_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Field extractor model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic name_hit();
    return key_ok && name_len >= 1 && name_len <= fde_pkg::MAX_KEY_CHARS &&
           key_pos == name_len;
  endfunction

  task automatic add_beat(input logic [7:0] data, input logic done, input logic found);
    step_beats.push_back('{data, done, found, 1'b0});
  endtask

  task automatic restart_field();
    parse_phase = fde_pkg::PH_KEY;
    key_pos = '0;
    key_ok = 1'b1;
    esc = fde_pkg::ESC_IDLE;
    hex_acc = '0;
  endtask

  task automatic put_decoded(input logic [7:0] c);
    if (c == fde_pkg::CH_NUL) begin
      parse_phase = fde_pkg::PH_STOP;
    end else if (c == fde_pkg::CH_GT) begin
      add_beat(fde_pkg::CH_AMP, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_G, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_T, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_SEMI, 1'b0, 1'b0);
    end else if (c == fde_pkg::CH_LT) begin
      add_beat(fde_pkg::CH_AMP, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_L, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_T, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_SEMI, 1'b0, 1'b0);
    end else if (c == fde_pkg::CH_NL) begin
      add_beat(fde_pkg::CH_LT, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_B, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_R, 1'b0, 1'b0);
      add_beat(fde_pkg::CH_GT, 1'b0, 1'b0);
    end else begin
      add_beat(c, 1'b0, 1'b0);
    end
  endtask

  task automatic value_char(input logic [7:0] c);
    int h;
    h = nibble_of(c);
    case (esc)
      fde_pkg::ESC_FIRST: begin
        if (h < 0) begin
          esc = fde_pkg::ESC_DROP;
        end else begin
          hex_acc = 8'(h);
          esc = fde_pkg::ESC_SECOND;
        end
      end
      fde_pkg::ESC_SECOND: begin
        // A bad second digit leaves the first digit alone as the value.
        if (h >= 0) hex_acc = {hex_acc[3:0], 4'(h)};
        esc = fde_pkg::ESC_IDLE;
        put_decoded(hex_acc);
      end
      fde_pkg::ESC_DROP: begin
        esc = fde_pkg::ESC_IDLE;
      end
      default: begin
        if (c == fde_pkg::CH_PCT) begin
          esc = fde_pkg::ESC_FIRST;
          hex_acc = '0;
        end else if (c == fde_pkg::CH_PLUS) begin
          add_beat(fde_pkg::CH_SPACE, 1'b0, 1'b0);
        end else begin
          put_decoded(c);
        end
      end
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] c, input logic fin);
    logic       done_sent;
    logic       hit;
    logic [7:0] want;
    done_sent = 1'b0;
    step_beats.delete();
    case (parse_phase)
      fde_pkg::PH_KEY: begin
        if (c == fde_pkg::CH_AMP) begin
          if (key_pos > 0 && name_hit()) begin
            add_beat(fde_pkg::CH_NUL, 1'b1, 1'b1);
            done_sent = 1'b1;
            parse_phase = fde_pkg::PH_DRAIN;
          end else begin
            restart_field();
          end
        end else if (c == fde_pkg::CH_EQ) begin
          // Leading '=' in a key are skipped.
          if (key_pos > 0) begin
            parse_phase = name_hit() ? fde_pkg::PH_EMIT : fde_pkg::PH_SKIP;
            esc = fde_pkg::ESC_IDLE;
            hex_acc = '0;
          end
        end else begin
          if (key_pos < name_len && key_pos < fde_pkg::MAX_KEY_CHARS) begin
            want = name_chars[8*key_pos +: 8];
            if (fold_case(want) != fold_case(c)) key_ok = 1'b0;
          end else begin
            key_ok = 1'b0;
          end
          if (key_pos <= fde_pkg::MAX_KEY_CHARS) key_pos = key_pos + 4'd1;
        end
      end
      fde_pkg::PH_SKIP: begin
        if (c == fde_pkg::CH_AMP) restart_field();
      end
      fde_pkg::PH_EMIT, fde_pkg::PH_STOP: begin
        if (c == fde_pkg::CH_AMP) begin
          add_beat(fde_pkg::CH_NUL, 1'b1, 1'b1);
          done_sent = 1'b1;
          parse_phase = fde_pkg::PH_DRAIN;
        end else if (parse_phase == fde_pkg::PH_EMIT) begin
          value_char(c);
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (!done_sent && parse_phase != fde_pkg::PH_DRAIN) begin
        hit = parse_phase == fde_pkg::PH_EMIT || parse_phase == fde_pkg::PH_STOP ||
              (parse_phase == fde_pkg::PH_KEY && key_pos > 0 && name_hit());
        add_beat(fde_pkg::CH_NUL, 1'b1, hit);
      end
      restart_field();
    end
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one raw byte per beat from the form stream.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    raw_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
      in_byte <= '0;
      in_is_final <= 1'b0;
    end else begin
      if (push && !full) predict_byte(in_byte, in_is_final);
      if (!push || !full) begin
        if (form_stream.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
          nxt = form_stream.pop_front();
          push <= 1'b1;
          in_byte <= nxt.data;
          in_is_final <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_beats
    beat_t seen;
    beat_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        seen = '{out_byte, out_is_done, out_found, out_run_last};
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected beat: byte %h done %b found %b last %b",
                     seen.data, seen.done, seen.found, seen.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (seen.data !== want.data || seen.done !== want.done ||
              seen.found !== want.found || seen.last !== want.last) begin
            if (mismatches < 10)
              $display({"mismatch: expected byte %h done %b found %b last %b, ",
                        "got byte %h done %b found %b last %b"},
                       want.data, want.done, want.found, want.last,
                       seen.data, seen.done, seen.found, seen.last);
            mismatches++;
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("form_field_extract_decode_unit_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic cfg_write(input fde_pkg::reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == fde_pkg::REG_KEY_CHARS) name_chars = val;
    else name_len = val[3:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (form_stream.size() != 0 || push || expected_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Moves the collected bytes into the stream; the last one closes the form.
  task automatic flush_form();
    if (form_bytes.size() == 0) form_bytes.push_back(8'($urandom_range(255)));
    foreach (form_bytes[i])
      form_stream.push_back('{form_bytes[i], i == form_bytes.size() - 1});
    queued_bytes += form_bytes.size();
    form_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) form_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return "0" + 8'(nib);
    return ($urandom_range(1) ? "a" : "A") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? "a" : "A") + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h7E, 8'h21));
    while (c == fde_pkg::CH_PCT || c == fde_pkg::CH_AMP || c == fde_pkg::CH_PLUS);
    return c;
  endfunction

  task automatic add_escape(input logic [7:0] v);
    form_bytes.push_back(fde_pkg::CH_PCT);
    form_bytes.push_back(hex_char(v[7:4]));
    form_bytes.push_back(hex_char(v[3:0]));
  endtask

  task automatic add_field();
    int         kind;
    int         klen;
    logic [7:0] c;
    klen = (name_len > fde_pkg::MAX_KEY_CHARS) ? fde_pkg::MAX_KEY_CHARS : int'(name_len);
    kind = $urandom_range(9);
    if (kind == 9) begin
      repeat ($urandom_range(2, 1)) form_bytes.push_back(fde_pkg::CH_EQ);
    end
    if (kind <= 6 || kind == 9) begin
      // The wanted name with random case, sometimes one short or one long.
      for (int i = 0; i < klen - (kind == 5); i++) begin
        c = name_chars[8*i +: 8];
        if (fold_case(c) >= "a" && fold_case(c) <= "z" && $urandom_range(1)) c ^= 8'h20;
        form_bytes.push_back(c);
      end
      if (kind == 6) form_bytes.push_back(rand_letter());
    end else if (kind == 7) begin
      repeat ($urandom_range(4, 1)) form_bytes.push_back(rand_letter());
    end
    if ($urandom_range(99) < 12) return;
    form_bytes.push_back(fde_pkg::CH_EQ);
    repeat ($urandom_range(3)) begin
      case ($urandom_range(19))
        7:       form_bytes.push_back(fde_pkg::CH_PLUS);
        8, 9:    add_escape(8'($urandom_range(255)));
        10:      add_escape(8'($urandom_range(8'h7E, 8'h20)));
        11: begin
          case ($urandom_range(2))
            0:       add_escape(fde_pkg::CH_LT);
            1:       add_escape(fde_pkg::CH_GT);
            default: add_escape(fde_pkg::CH_NL);
          endcase
        end
        12: begin
          form_bytes.push_back(fde_pkg::CH_PCT);
          form_bytes.push_back(8'h47 + 8'($urandom_range(19)));
          form_bytes.push_back(plain_char());
        end
        13: begin
          form_bytes.push_back(fde_pkg::CH_PCT);
          form_bytes.push_back(hex_char(4'($urandom_range(15))));
          form_bytes.push_back(8'h47 + 8'($urandom_range(19)));
        end
        14: begin
          case ($urandom_range(2))
            0:       form_bytes.push_back(fde_pkg::CH_LT);
            1:       form_bytes.push_back(fde_pkg::CH_GT);
            default: form_bytes.push_back(fde_pkg::CH_NL);
          endcase
        end
        15:      add_escape(fde_pkg::CH_NUL);
        16:      form_bytes.push_back(8'($urandom_range(255)));
        17: begin
          // Escape cut short by whatever follows.
          form_bytes.push_back(fde_pkg::CH_PCT);
          if ($urandom_range(1)) form_bytes.push_back(hex_char(4'($urandom_range(15))));
        end
        default: form_bytes.push_back(plain_char());
      endcase
    end
  endtask

  task automatic add_random_form();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 1)) form_bytes.push_back(8'($urandom_range(255)));
    end else begin
      add_field();
      repeat ($urandom_range(1)) begin
        form_bytes.push_back(fde_pkg::CH_AMP);
        add_field();
      end
      if ($urandom_range(9) == 0) form_bytes.push_back(fde_pkg::CH_AMP);
    end
    flush_form();
  endtask

  initial begin : run_test
    logic [63:0] chars;
    logic [3:0]  len;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (!rst_n) @(posedge clk);

    // Directed forms with the name "ab".
    chars = {$urandom(), $urandom()};
    chars[15:0] = {"b", "a"};
    cfg_write(fde_pkg::REG_KEY_CHARS, chars);
    cfg_write(fde_pkg::REG_KEY_LENGTH, 64'd2);
    add_text("=x&Ab=+%3C%0a<\n%g1%4z%");
    flush_form();
    add_text("aB&z");
    flush_form();
    add_text("ab=%3e");
    form_bytes.push_back(8'hFF);
    form_bytes.push_back(fde_pkg::CH_NUL);
    form_bytes.push_back("q");
    flush_form();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      chars = {$urandom(), $urandom()};
      case (p)
        0:       len = 4'd8;
        1:       len = 4'd1;
        2:       len = 4'd4;
        3:       len = 4'd0;
        4:       len = 4'd15;
        5:       len = 4'd9;
        default: len = 4'd6;
      endcase
      for (int i = 0; i < fde_pkg::MAX_KEY_CHARS; i++)
        if (i < len) chars[8*i +: 8] = rand_letter();
      if (p == 3) chars = '0;
      if (p == 4) chars = '1;
      steady = (p == 2);
      cfg_write(fde_pkg::REG_KEY_CHARS, chars);
      cfg_write(fde_pkg::REG_KEY_LENGTH, 64'(len));
      queued_bytes = 0;
      while (queued_bytes < PHASE_BYTES) add_random_form();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("form_field_extract_decode_unit_tb: clean");
    end else begin
      $display("form_field_extract_decode_unit_tb: errors");
    end
    $finish;
  end

endmodule
